// ----- design/les_pkg.sv -----
// Package for the Lorenz Euler integrator: fixed-point format, register
// reset values, register indexes and the control word of the shared add unit.
// No dependencies.
`timescale 1ns / 1ps

package les_pkg;

    localparam int FRAC_BITS = 24;
    localparam int VAL_W     = 32;
    localparam int COEF_W    = 31;
    localparam int DT_W      = 24;
    localparam int SUM_W     = VAL_W + 2;
    localparam int PROD_W    = 2 * VAL_W;

    // reset values: 8/3 rounded, 10, 28 and 0.001 truncated
    localparam logic [COEF_W-1:0] BETA_RESET  =
        COEF_W'(((64'd8 << FRAC_BITS) + 64'd1) / 64'd3);
    localparam logic [COEF_W-1:0] SIGMA_RESET = COEF_W'(64'd10 << FRAC_BITS);
    localparam logic [COEF_W-1:0] RHO_RESET   = COEF_W'(64'd28 << FRAC_BITS);
    localparam logic [DT_W-1:0]   DT_RESET    = DT_W'((64'd1 << FRAC_BITS) / 64'd1000);

    // configuration register indexes
    localparam logic [1:0] CFG_BETA  = 2'd0;
    localparam logic [1:0] CFG_SIGMA = 2'd1;
    localparam logic [1:0] CFG_RHO   = 2'd2;
    localparam logic [1:0] CFG_DT    = 2'd3;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // add unit operand A sources
    localparam logic [2:0] AS_ZERO = 3'd0;
    localparam logic [2:0] AS_X    = 3'd1;
    localparam logic [2:0] AS_Y    = 3'd2;
    localparam logic [2:0] AS_Z    = 3'd3;
    localparam logic [2:0] AS_RHO  = 3'd4;
    localparam logic [2:0] AS_T0   = 3'd5;
    localparam logic [2:0] AS_P    = 3'd6;

    // add unit operand B sources
    localparam logic [1:0] BS_X = 2'd0;
    localparam logic [1:0] BS_Y = 2'd1;
    localparam logic [1:0] BS_Z = 2'd2;
    localparam logic [1:0] BS_P = 2'd3;

    typedef struct packed {
        logic [2:0] a_sel;
        logic [1:0] b_sel;
        logic       sub;
    } t_alu_ctl;

endpackage

// ----- design/les_alu.sv -----
// Shared saturating add/subtract unit of the Lorenz Euler integrator.
// Takes the registered product, scales and clamps it, then adds or subtracts
// two selected operands with clamping. Depends on les_pkg.
`timescale 1ns / 1ps

module les_alu (
    input  les_pkg::t_alu_ctl                 i_ctl,
    input  logic signed [les_pkg::VAL_W-1:0]  i_x,
    input  logic signed [les_pkg::VAL_W-1:0]  i_y,
    input  logic signed [les_pkg::VAL_W-1:0]  i_z,
    input  logic signed [les_pkg::VAL_W-1:0]  i_t0,
    input  logic        [les_pkg::COEF_W-1:0] i_rho,
    input  logic signed [les_pkg::PROD_W-1:0] i_prod,
    output logic signed [les_pkg::VAL_W-1:0]  o_res,
    output logic                              o_clamp
);
    import les_pkg::*;

    localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic signed [PROD_W-1:0] p_shift;
    logic [PROD_W-VAL_W:0]    p_hi;
    logic signed [VAL_W-1:0]  p_val;
    logic                     p_clamp;
    logic                     p_used;
    logic signed [SUM_W-1:0]  op_a;
    logic signed [SUM_W-1:0]  op_b;
    logic signed [SUM_W-1:0]  sum;
    logic                     s_clamp;

    // floor scaling of the product, then clamp to the value range
    always_comb begin
        p_shift = i_prod >>> FRAC_BITS;
        p_hi    = p_shift[PROD_W-1:VAL_W-1];
        p_clamp = !((&p_hi) || !(|p_hi));
        if (!p_clamp) begin
            p_val = p_shift[VAL_W-1:0];
        end else if (p_shift[PROD_W-1]) begin
            p_val = VMIN;
        end else begin
            p_val = VMAX;
        end
    end

    always_comb begin
        case (i_ctl.a_sel)
            AS_X:    op_a = SUM_W'(i_x);
            AS_Y:    op_a = SUM_W'(i_y);
            AS_Z:    op_a = SUM_W'(i_z);
            AS_RHO:  op_a = {{(SUM_W-COEF_W){1'b0}}, i_rho};
            AS_T0:   op_a = SUM_W'(i_t0);
            AS_P:    op_a = SUM_W'(p_val);
            default: op_a = '0;
        endcase
        case (i_ctl.b_sel)
            BS_X:    op_b = SUM_W'(i_x);
            BS_Y:    op_b = SUM_W'(i_y);
            BS_Z:    op_b = SUM_W'(i_z);
            default: op_b = SUM_W'(p_val);
        endcase
        p_used = (i_ctl.a_sel == AS_P) || (i_ctl.b_sel == BS_P);
        sum    = i_ctl.sub ? (op_a - op_b) : (op_a + op_b);
        s_clamp = !((&sum[SUM_W-1:VAL_W-1]) || !(|sum[SUM_W-1:VAL_W-1]));
        if (!s_clamp) begin
            o_res = sum[VAL_W-1:0];
        end else if (sum[SUM_W-1]) begin
            o_res = VMIN;
        end else begin
            o_res = VMAX;
        end
        o_clamp = s_clamp || (p_used && p_clamp);
    end

endmodule

// ----- design/lorenz_euler_step.sv -----
// Lorenz system integrator, one forward Euler step per step item.
// Input channel: i_valid / o_ready with i_opcode and i_init_x/y/z.
// Output channel: o_valid / i_ready with o_out_x/y/z and o_saturated.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 beta, 1 sigma, 2 rho, 3 time step); write only while idle.
// A load item sets the state and returns it, saturated 0; it passes from
// idle to the done state and then into the output register. A step item runs
// a counted sequence on one shared 32x32 multiplier (product registered) and
// one saturating add unit, issuing seven products one after another; each
// product is registered before the add unit reads it. o_ready is high only
// while idle, so no new item is taken before the last one leaves done.
// The result stays in an output register; the next item is taken while it
// waits, but a finished item holds in the done state until the register is
// free, so a stalled receiver stops the block after one item.
// Reset clears the state to zero, loads the default coefficients and
// drops any pending result.
`timescale 1ns / 1ps

module lorenz_euler_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_opcode,
    input  logic signed [les_pkg::VAL_W-1:0]  i_init_x,
    input  logic signed [les_pkg::VAL_W-1:0]  i_init_y,
    input  logic signed [les_pkg::VAL_W-1:0]  i_init_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [les_pkg::VAL_W-1:0]  o_out_x,
    output logic signed [les_pkg::VAL_W-1:0]  o_out_y,
    output logic signed [les_pkg::VAL_W-1:0]  o_out_z,
    output logic                              o_saturated,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [les_pkg::COEF_W-1:0]        i_cfg_data
);
    import les_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int RUN_LAST = 9;
    localparam int CNT_W    = $clog2(RUN_LAST + 1);

    localparam logic [1:0] MA_SIGMA = 2'd0;
    localparam logic [1:0] MA_X     = 2'd1;
    localparam logic [1:0] MA_DT    = 2'd2;
    localparam logic [1:0] MA_BETA  = 2'd3;
    localparam logic [1:0] MB_T0    = 2'd0;
    localparam logic [1:0] MB_T1    = 2'd1;
    localparam logic [1:0] MB_Y     = 2'd2;
    localparam logic [1:0] MB_Z     = 2'd3;

    localparam logic [2:0] D_NONE = 3'd0;
    localparam logic [2:0] D_T0   = 3'd1;
    localparam logic [2:0] D_T1   = 3'd2;
    localparam logic [2:0] D_NX   = 3'd3;
    localparam logic [2:0] D_NY   = 3'd4;
    localparam logic [2:0] D_NZ   = 3'd5;

    logic [1:0]               r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [COEF_W-1:0]        r_beta;
    logic [COEF_W-1:0]        r_sigma;
    logic [COEF_W-1:0]        r_rho;
    logic [DT_W-1:0]          r_dt;
    logic signed [VAL_W-1:0]  r_x;
    logic signed [VAL_W-1:0]  r_y;
    logic signed [VAL_W-1:0]  r_z;
    logic signed [VAL_W-1:0]  r_nx;
    logic signed [VAL_W-1:0]  r_ny;
    logic signed [VAL_W-1:0]  r_nz;
    logic signed [VAL_W-1:0]  r_t0;
    logic signed [VAL_W-1:0]  r_t1;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_sat;
    logic                     r_ov;
    logic signed [VAL_W-1:0]  r_ox;
    logic signed [VAL_W-1:0]  r_oy;
    logic signed [VAL_W-1:0]  r_oz;
    logic                     r_osat;

    t_alu_ctl                 alu_ctl;
    logic [2:0]               alu_dst;
    logic [1:0]               ma_sel;
    logic [1:0]               mb_sel;
    logic signed [VAL_W-1:0]  mul_a;
    logic signed [VAL_W-1:0]  mul_b;
    logic signed [VAL_W-1:0]  alu_res;
    logic                     alu_clamp;
    logic                     in_acc;
    logic                     commit;

    assign o_ready     = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign commit      = (r_state == ST_DONE) && (!r_ov || i_ready);
    assign o_valid     = r_ov;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_z     = r_oz;
    assign o_saturated = r_osat;

    // step schedule: the add unit at count n reads the product issued at n-1
    always_comb begin
        alu_ctl = '{a_sel: AS_ZERO, b_sel: BS_P, sub: 1'b0};
        alu_dst = D_NONE;
        ma_sel  = MA_DT;
        mb_sel  = MB_T1;
        case (r_cnt)
            CNT_W'(0): begin
                alu_ctl = '{a_sel: AS_Y, b_sel: BS_X, sub: 1'b1};
                alu_dst = D_T0;
            end
            CNT_W'(1): begin
                ma_sel  = MA_SIGMA;
                mb_sel  = MB_T0;
                alu_ctl = '{a_sel: AS_RHO, b_sel: BS_Z, sub: 1'b1};
                alu_dst = D_T1;
            end
            CNT_W'(2): begin
                ma_sel  = MA_X;
                mb_sel  = MB_T1;
                alu_dst = D_T0;
            end
            CNT_W'(3): begin
                ma_sel  = MA_DT;
                mb_sel  = MB_T0;
                alu_ctl = '{a_sel: AS_P, b_sel: BS_Y, sub: 1'b1};
                alu_dst = D_T1;
            end
            CNT_W'(4): begin
                ma_sel  = MA_X;
                mb_sel  = MB_Y;
                alu_ctl = '{a_sel: AS_X, b_sel: BS_P, sub: 1'b0};
                alu_dst = D_NX;
            end
            CNT_W'(5): begin
                ma_sel  = MA_DT;
                mb_sel  = MB_T1;
                alu_dst = D_T0;
            end
            CNT_W'(6): begin
                ma_sel  = MA_BETA;
                mb_sel  = MB_Z;
                alu_ctl = '{a_sel: AS_Y, b_sel: BS_P, sub: 1'b0};
                alu_dst = D_NY;
            end
            CNT_W'(7): begin
                alu_ctl = '{a_sel: AS_T0, b_sel: BS_P, sub: 1'b1};
                alu_dst = D_T1;
            end
            CNT_W'(8): begin
                ma_sel  = MA_DT;
                mb_sel  = MB_T1;
            end
            CNT_W'(9): begin
                alu_ctl = '{a_sel: AS_Z, b_sel: BS_P, sub: 1'b0};
                alu_dst = D_NZ;
            end
            default: begin
                alu_dst = D_NONE;
            end
        endcase
    end

    always_comb begin
        case (ma_sel)
            MA_SIGMA: mul_a = {{(VAL_W-COEF_W){1'b0}}, r_sigma};
            MA_X:     mul_a = r_x;
            MA_DT:    mul_a = {{(VAL_W-DT_W){1'b0}}, r_dt};
            default:  mul_a = {{(VAL_W-COEF_W){1'b0}}, r_beta};
        endcase
        case (mb_sel)
            MB_T0:   mul_b = r_t0;
            MB_T1:   mul_b = r_t1;
            MB_Y:    mul_b = r_y;
            default: mul_b = r_z;
        endcase
    end

    les_alu u_alu (
        .i_ctl   (alu_ctl),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_z     (r_z),
        .i_t0    (r_t0),
        .i_rho   (r_rho),
        .i_prod  (r_prod),
        .o_res   (alu_res),
        .o_clamp (alu_clamp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta  <= BETA_RESET;
            r_sigma <= SIGMA_RESET;
            r_rho   <= RHO_RESET;
            r_dt    <= DT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BETA:  r_beta  <= i_cfg_data;
                CFG_SIGMA: r_sigma <= i_cfg_data;
                CFG_RHO:   r_rho   <= i_cfg_data;
                CFG_DT:    r_dt    <= i_cfg_data[DT_W-1:0];
                default:   r_dt    <= r_dt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_sat   <= 1'b0;
            r_ov    <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
        end else begin
            if (commit) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_sat <= 1'b0;
                        r_cnt <= '0;
                        if (i_opcode == OP_LOAD) begin
                            r_nx    <= i_init_x;
                            r_ny    <= i_init_y;
                            r_nz    <= i_init_z;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_prod <= mul_a * mul_b;
                    if (alu_dst != D_NONE) begin
                        r_sat <= r_sat | alu_clamp;
                    end
                    case (alu_dst)
                        D_T0:    r_t0 <= alu_res;
                        D_T1:    r_t1 <= alu_res;
                        D_NX:    r_nx <= alu_res;
                        D_NY:    r_ny <= alu_res;
                        D_NZ:    r_nz <= alu_res;
                        default: r_t0 <= r_t0;
                    endcase
                    if (r_cnt == CNT_W'(RUN_LAST)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (commit) begin
                        r_x     <= r_nx;
                        r_y     <= r_ny;
                        r_z     <= r_nz;
                        r_ox    <= r_nx;
                        r_oy    <= r_ny;
                        r_oz    <= r_nz;
                        r_osat  <= r_sat;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_opcode == OP_LOAD) |=> (r_state == ST_DONE))
        else $error("load item did not go straight to done");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt == CNT_W'(RUN_LAST)) |=> (r_state == ST_DONE))
        else $error("step sequence did not end in done");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!commit) |=> ($stable(r_x) && $stable(r_y) && $stable(r_z)))
        else $error("state changed outside commit");

    a_sat_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !r_sat)
        else $error("saturation flag not cleared on new item");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_ov && r_ox == r_x && r_oy == r_y && r_oz == r_z))
        else $error("output does not match committed state");

endmodule
